FILE: hdl/gta_pkg.sv
// Shared types, constants and binary64 helpers for the 4x4 tile engine.
`timescale 1ns / 1ps
package gta_pkg;

  localparam int unsigned Dim      = 4;
  localparam int unsigned NumAcc   = Dim * Dim;
  localparam int unsigned RowW     = $clog2(Dim);
  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] InfBits  = 64'h7FF0_0000_0000_0000;

  typedef logic [63:0] f64_t;

  typedef struct packed {
    f64_t [Dim-1:0] a_row;
    f64_t [Dim-1:0] b_col;
    logic           clear_first;
    logic           last_term;
  } in_req_t;

  typedef struct packed {
    logic [RowW-1:0] tile_row;
    f64_t [Dim-1:0]  sum_col;
    logic            last_row;
  } out_req_t;

  // Special-case outcome of one FMA, settled in the first stage.
  typedef struct packed {
    logic       done;    // result known without the datapath
    f64_t       value;   // that result
    logic       zc;      // accumulator operand is zero
  } fma_spec_t;

  // Index of the highest set bit, 128-bit operand.
  function automatic logic [6:0] msb128(input logic [127:0] x);
    logic [6:0] m;
    m = 7'd0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) m = 7'(i);
    end
    return m;
  endfunction

endpackage

FILE: hdl/gta_if.sv
// Valid/ready channel interface carrying one request payload.
`timescale 1ns / 1ps
interface gta_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/gta_fma.sv
// One binary64 fused multiply-add lane, four register stages.
`timescale 1ns / 1ps
module gta_fma (
  input  logic            clk_i,
  input  logic            en_i,
  input  gta_pkg::f64_t   a_i,
  input  gta_pkg::f64_t   b_i,
  input  gta_pkg::f64_t   c_i,
  output gta_pkg::f64_t   r_o
);
  import gta_pkg::*;

  // stage 1: decode, special cases, split mantissa product
  logic        sa, sb, sc, sp;
  logic [10:0] xa, xb, xc;
  logic [51:0] fa, fb, fc;
  logic        za, zb, zc, ia, ib, ic;
  logic [52:0] ma, mb;
  fma_spec_t   spec_d, spec1_q, spec2_q, spec3_q;
  logic        sp1_q, sc1_q;
  logic signed [13:0] ep1_d, ep1_q, ec1_d, ec1_q;
  logic [105:0] pll_q, plh_q, phl_q, phh_q;
  logic [52:0]  mc1_q;

  always_comb begin
    sa = a_i[63]; sb = b_i[63]; sc = c_i[63]; sp = sa ^ sb;
    xa = a_i[62:52]; xb = b_i[62:52]; xc = c_i[62:52];
    fa = a_i[51:0]; fb = b_i[51:0]; fc = c_i[51:0];
    za = (xa == '0) && (fa == '0);
    zb = (xb == '0) && (fb == '0);
    zc = (xc == '0) && (fc == '0);
    ia = &xa; ib = &xb; ic = &xc;
    ma = (xa != '0) ? {1'b1, fa} : {1'b0, fa};
    mb = (xb != '0) ? {1'b1, fb} : {1'b0, fb};
    ep1_d = ((xa != '0) ? $signed({3'b0, xa}) - 14'sd1075 : -14'sd1074)
          + ((xb != '0) ? $signed({3'b0, xb}) - 14'sd1075 : -14'sd1074);
    ec1_d = (xc != '0) ? $signed({3'b0, xc}) - 14'sd1075 : -14'sd1074;
    spec_d.zc = zc;
    spec_d.done = 1'b1;
    spec_d.value = '0;
    if ((ia && fa != '0) || (ib && fb != '0) || (ic && fc != '0)) begin
      spec_d.value = QnanBits;
    end else if (ia || ib) begin
      if (za || zb || (ic && sc != sp)) spec_d.value = QnanBits;
      else spec_d.value = {sp, InfBits[62:0]};
    end else if (ic) begin
      spec_d.value = c_i;
    end else if (za || zb) begin
      spec_d.value = zc ? {(sc == sp) ? sc : 1'b0, 63'd0} : c_i;
    end else begin
      spec_d.done = 1'b0;
    end
  end

  // 53x53 split into four 27-ish partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec1_q <= spec_d;
      sp1_q   <= sp;
      sc1_q   <= sc;
      ep1_q   <= ep1_d;
      ec1_q   <= ec1_d;
      mc1_q   <= (xc != '0) ? {1'b1, fc} : {1'b0, fc};
      pll_q   <= 106'(ma[26:0] * mb[26:0]);
      plh_q   <= 106'(ma[26:0] * mb[52:27]);
      phl_q   <= 106'(ma[52:27] * mb[26:0]);
      phh_q   <= 106'(ma[52:27] * mb[52:27]);
    end
  end

  // stage 2: sum partials, normalise product and addend to bit 126
  logic [127:0] p2_d, c2_d, p2_q, c2_q;
  logic signed [13:0] ep2_d, ec2_d, ep2_q, ec2_q;
  logic sp2_q, sc2_q;
  logic [6:0] pm, cm;
  logic [127:0] praw;

  always_comb begin
    praw = 128'(pll_q) + (128'(plh_q) << 27) + (128'(phl_q) << 27)
         + (128'(phh_q) << 54);
    pm = msb128(praw);
    cm = msb128({75'd0, mc1_q});
    p2_d = praw << (7'd126 - pm);
    c2_d = {75'd0, mc1_q} << (7'd126 - cm);
    ep2_d = ep1_q - $signed({7'd0, 7'd126 - pm});
    ec2_d = ec1_q - $signed({7'd0, 7'd126 - cm});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec2_q <= spec1_q;
      p2_q <= p2_d; c2_q <= c2_d; ep2_q <= ep2_d; ec2_q <= ec2_d;
      sp2_q <= sp1_q; sc2_q <= sc1_q;
    end
  end

  // stage 3: align and add
  logic [127:0] big, sml, sh, sum3_d, sum3_q;
  logic signed [13:0] eb, es, ediff;
  logic sbig, ssml, sgn3_q, zero3_d, zero3_q;
  logic signed [13:0] e3_q;
  logic sticky;

  always_comb begin
    if (spec2_q.zc || ep2_q > ec2_q || (ep2_q == ec2_q && p2_q >= c2_q)) begin
      big = p2_q; sbig = sp2_q; eb = ep2_q;
      sml = c2_q; ssml = sc2_q; es = ec2_q;
    end else begin
      big = c2_q; sbig = sc2_q; eb = ec2_q;
      sml = p2_q; ssml = sp2_q; es = ep2_q;
    end
    ediff = eb - es;
    if (spec2_q.zc) begin
      sh = '0; sticky = 1'b0;
    end else if (ediff >= 14'sd128) begin
      sh = '0; sticky = |sml;
    end else begin
      sh = sml >> ediff[6:0];
      sticky = |(sml & ~({128{1'b1}} << ediff[6:0]));
    end
    sh[0] = sh[0] | sticky;
    sum3_d = (sbig == ssml) ? big + sh : big - sh;
    zero3_d = (sum3_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec3_q <= spec2_q;
      sum3_q <= sum3_d; e3_q <= eb; sgn3_q <= sbig; zero3_q <= zero3_d;
    end
  end

  // stage 4: round to nearest even and pack
  logic [6:0] m4;
  logic signed [13:0] r4, rs4, k4;
  logic [63:0] q4, bits4;
  logic half4, stk4;
  logic [127:0] shd;
  f64_t res_d, res_q;

  always_comb begin
    m4  = msb128(sum3_q);
    r4  = $signed({7'd0, m4}) - 14'sd52;
    rs4 = -14'sd1074 - e3_q;
    if (rs4 > r4) r4 = rs4;
    half4 = 1'b0; stk4 = 1'b0;
    if (r4 <= 0) begin
      shd = sum3_q << 7'(-r4);
      q4 = shd[63:0];
    end else if (r4 >= 14'sd128) begin
      q4 = '0;
    end else begin
      shd = sum3_q >> r4[6:0];
      q4 = shd[63:0];
      half4 = sum3_q[7'(r4 - 14'sd1)];
      stk4 = |(sum3_q & ~({128{1'b1}} << 7'(r4 - 14'sd1)));
      if (half4 && (stk4 || q4[0])) q4 = q4 + 64'd1;
    end
    if (r4 <= 0) shd = sum3_q << 7'(-r4);
    else if (r4 < 14'sd128) shd = sum3_q >> r4[6:0];
    else shd = '0;
    k4 = r4 + e3_q + 14'sd1074;
    bits4 = {k4[11:0], 52'd0} + q4;
    if (spec3_q.done) res_d = spec3_q.value;
    else if (zero3_q) res_d = '0;
    else if (k4 > 14'sd2046 || bits4 >= InfBits) res_d = {sgn3_q, InfBits[62:0]};
    else res_d = {sgn3_q, bits4[62:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign r_o = res_q;

endmodule

FILE: hdl/gta_emit.sv
// Output stage: holds a finished tile and hands it out row by row.
`timescale 1ns / 1ps
module gta_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  gta_pkg::f64_t [gta_pkg::NumAcc-1:0] tile_i,
  output logic                       busy_o,
  output logic                       held_o,
  gta_if.source                      out_o
);
  import gta_pkg::*;

  f64_t [NumAcc-1:0] tile_q, pend_q;
  logic [RowW-1:0]   row_q, row_d;
  logic              act_q, act_d, pend_v_q, pend_v_d;
  logic              fin, load_act, load_pend, take_pend;

  // last row of the tile being handed out leaves this cycle
  assign fin = act_q && out_o.ready && (row_q == RowW'(Dim - 1));

  always_comb begin
    row_d     = row_q;
    act_d     = act_q;
    pend_v_d  = pend_v_q;
    load_act  = 1'b0;
    load_pend = 1'b0;
    take_pend = 1'b0;
    if (act_q && out_o.ready) row_d = row_q + 1'b1;
    if (fin) begin
      if (pend_v_q) begin
        take_pend = 1'b1; pend_v_d = 1'b0;
      end else begin
        act_d = 1'b0;
      end
    end
    // a new tile goes straight out if the row slot is free, else waits aside
    if (load_i) begin
      if (!act_q || (fin && !pend_v_q)) begin
        load_act = 1'b1; act_d = 1'b1; row_d = '0;
      end else begin
        load_pend = 1'b1; pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      row_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      row_q    <= row_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_act) tile_q <= tile_i;
    else if (take_pend) tile_q <= pend_q;
    if (load_pend) pend_q <= tile_i;
  end

  always_comb begin
    out_o.valid = act_q;
    out_o.data.tile_row = row_q;
    out_o.data.last_row = (row_q == RowW'(Dim - 1));
    for (int j = 0; j < Dim; j++) begin
      out_o.data.sum_col[j] = tile_q[{row_q, RowW'(j)}];
    end
  end

  assign busy_o = act_q;
  assign held_o = pend_v_q;

endmodule

FILE: hdl/gemm_tile_4x4_accumulate.sv
// Top level: 4x4 binary64 tile multiply-accumulate engine.
`timescale 1ns / 1ps
// Channel  Dir  Handshake       Payload
// in_i     in   valid/ready     a_row[4], b_col[4], clear_first, last_term
// out_o    out  valid/ready     tile_row, sum_col[4], last_row
//
// Sixteen FMA lanes, four stages each, one per accumulator. The stage-4
// result feeds back as the addend, so a new request is taken only when the
// previous request's results land; that loop sets the rate. A finished tile
// is offered one row per cycle while out_o is ready. The emitter keeps one
// spare tile; a last request waits while that spare is taken, or while a
// tile is being handed out and another finishing tile is still in the lanes.
// Reset clears control and the accumulators to +0.
module gemm_tile_4x4_accumulate (
  input  logic  clk_i,
  input  logic  rst_ni,
  gta_if.sink   in_i,
  gta_if.source out_o
);
  import gta_pkg::*;

  // slot counter: request admitted in slot 0, result written back in slot 0
  logic [1:0]        slot_q;
  logic              run_q, last_q, emit_busy, emit_held;
  f64_t [NumAcc-1:0] acc_q, lane_r, addend;
  in_req_t           req;
  logic              take, done;

  assign req  = in_i.data;
  // a finishing tile must always find a free buffer at the emitter
  assign in_i.ready = (slot_q == 2'd0)
                   && !(req.last_term && (emit_held || (emit_busy && run_q && last_q)));
  assign take = in_i.valid && in_i.ready;
  assign done = run_q && (slot_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      run_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (take || slot_q != 2'd0) slot_q <= slot_q + 2'd1;
      if (take) begin
        run_q <= 1'b1; last_q <= req.last_term;
      end else if (done) begin
        run_q <= 1'b0;
      end
    end
  end

  // accumulators: written when a lane result lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else if (done) acc_q <= lane_r;
  end

  // the value of acc includes the lane result landing this very cycle
  always_comb begin
    for (int n = 0; n < NumAcc; n++) begin
      addend[n] = req.clear_first ? '0 : (done ? lane_r[n] : acc_q[n]);
    end
  end

  for (genvar i = 0; i < Dim; i++) begin : g_row
    for (genvar j = 0; j < Dim; j++) begin : g_col
      gta_fma u_lane (
        .clk_i (clk_i),
        .en_i  (1'b1),
        .a_i   (req.a_row[i]),
        .b_i   (req.b_col[j]),
        .c_i   (addend[i*Dim+j]),
        .r_o   (lane_r[i*Dim+j])
      );
    end
  end

  gta_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (done && last_q),
    .tile_i (lane_r),
    .busy_o (emit_busy),
    .held_o (emit_held),
    .out_o  (out_o)
  );

endmodule

FILE: bench/tb_gemm_tile_4x4_accumulate.sv
// Testbench for the 4x4 binary64 tile multiply-accumulate engine.
`timescale 1ns / 1ps
module tb_gemm_tile_4x4_accumulate;
  import gta_pkg::*;

  localparam int unsigned IdlePct   = 38;
  localparam int unsigned StallLim  = 5000;  // cycles with no request moved
  localparam int unsigned DrainCyc  = 24;    // block latency plus margin

  localparam logic [63:0] PosZero = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
  localparam logic [63:0] One     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] MaxFin  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNorm = 64'h0010_0000_0000_0000;
  localparam logic [63:0] MinSub  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] MaxSub  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SigNan  = 64'h7FF0_0000_0000_0001;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gta_if #(.payload_t(in_req_t))  in_ch ();
  gta_if #(.payload_t(out_req_t)) out_ch ();

  gemm_tile_4x4_accumulate uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk = ~clk;

  // Predicted accumulator tile and the rows still owed by the block.
  f64_t     acc_tile [NumAcc];
  out_req_t rows_due [$];

  int unsigned in_idle  = IdlePct;
  int unsigned out_idle = IdlePct;
  int unsigned errors   = 0;
  int unsigned n_sent   = 0;
  int unsigned n_rows   = 0;
  int unsigned n_tiles  = 0;
  int unsigned quiet    = 0;

  // ---------------- binary64 arithmetic ----------------
  function automatic int top_bit(logic [127:0] x);
    int m;
    m = -1;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) m = i;
    end
    return m;
  endfunction

  function automatic bit any_below(logic [127:0] x, int n);
    if (n <= 0) return 1'b0;
    if (n >= 128) return x != '0;
    return (x & ((128'd1 << n) - 128'd1)) != '0;
  endfunction

  // Round sign * s * 2^e to binary64 (s nonzero), nearest-even.
  function automatic f64_t round_f64(logic sgn, logic [127:0] s, int e);
    int   r, rs, k;
    bit   half, sticky;
    f64_t q, bits;
    r  = top_bit(s) - 52;
    rs = -1074 - e;
    if (rs > r) r = rs;
    if (r <= 0) begin
      q = 64'(s << (-r));
    end else begin
      half   = (r - 1 < 128) ? s[r-1] : 1'b0;
      sticky = any_below(s, r - 1);
      q      = 64'(s >> r);
      if (half && (sticky || q[0])) q = q + 64'd1;
    end
    k = r + e + 1074;
    if (k > 2046) return {sgn, InfBits[62:0]};
    bits = (64'(k) << 52) + q;
    if (bits >= InfBits) bits = InfBits;
    return {sgn, bits[62:0]};
  endfunction

  // a * b + c with a single rounding.
  function automatic f64_t fma_f64(f64_t a, f64_t b, f64_t c);
    logic         sp, sc, sbig, ssmall;
    int           xa, xb, xc, ea, eb, ep, ec, sh, ebig, esmall;
    logic [51:0]  fa, fb, fc;
    bit           za, zb, zc, ia, ib, ic;
    logic [63:0]  ma, mb;
    logic [127:0] p, cw, big, sml, sum;
    sp = a[63] ^ b[63];
    sc = c[63];
    xa = int'(a[62:52]); xb = int'(b[62:52]); xc = int'(c[62:52]);
    fa = a[51:0]; fb = b[51:0]; fc = c[51:0];
    za = (xa == 0) && (fa == '0);
    zb = (xb == 0) && (fb == '0);
    zc = (xc == 0) && (fc == '0);
    ia = xa == 2047; ib = xb == 2047; ic = xc == 2047;
    if ((ia && fa != '0) || (ib && fb != '0) || (ic && fc != '0)) return QnanBits;
    if (ia || ib) begin
      if (za || zb) return QnanBits;           // inf times zero
      if (ic && sc != sp) return QnanBits;     // inf minus inf
      return {sp, InfBits[62:0]};
    end
    if (ic) return c;
    if (za || zb) begin
      if (zc) return {(sc == sp) ? sc : 1'b0, 63'd0};
      return c;
    end
    ma = (xa != 0) ? {11'd0, 1'b1, fa} : {12'd0, fa};
    mb = (xb != 0) ? {11'd0, 1'b1, fb} : {12'd0, fb};
    ea = (xa != 0) ? xa - 1075 : -1074;
    eb = (xb != 0) ? xb - 1075 : -1074;
    p  = {64'd0, ma} * {64'd0, mb};
    ep = ea + eb;
    sh = 126 - top_bit(p);
    p  = p << sh;
    ep = ep - sh;
    if (zc) return round_f64(sp, p, ep);
    cw = (xc != 0) ? {75'd0, 1'b1, fc} : {76'd0, fc};
    ec = (xc != 0) ? xc - 1075 : -1074;
    sh = 126 - top_bit(cw);
    cw = cw << sh;
    ec = ec - sh;
    if (ep > ec || (ep == ec && p >= cw)) begin
      big = p;  sbig = sp; ebig = ep; sml = cw; ssmall = sc; esmall = ec;
    end else begin
      big = cw; sbig = sc; ebig = ec; sml = p;  ssmall = sp; esmall = ep;
    end
    // align the smaller term, keeping lost bits as a sticky bit
    sh = ebig - esmall;
    if (any_below(sml, sh)) sml = (sml >> sh) | 128'd1;
    else sml = sml >> sh;
    if (sbig == ssmall) begin
      sum = big + sml;
    end else begin
      sum = big - sml;
      if (sum == '0) return PosZero;           // exact cancellation gives +0
    end
    return round_f64(sbig, sum, ebig);
  endfunction

  // Apply one accepted request to the predicted tile; queue rows if last.
  task automatic apply_request(in_req_t r);
    out_req_t row;
    if (r.clear_first) begin
      for (int i = 0; i < NumAcc; i++) acc_tile[i] = PosZero;
    end
    for (int i = 0; i < Dim; i++) begin
      for (int j = 0; j < Dim; j++) begin
        acc_tile[i*Dim+j] = fma_f64(r.a_row[i], r.b_col[j], acc_tile[i*Dim+j]);
      end
    end
    if (r.last_term) begin
      for (int i = 0; i < Dim; i++) begin
        row.tile_row = RowW'(i);
        for (int j = 0; j < Dim; j++) row.sum_col[j] = acc_tile[i*Dim+j];
        row.last_row = (i == Dim - 1);
        rows_due.push_back(row);
      end
      n_tiles++;
    end
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic f64_t rand_raw();
    return {$urandom, $urandom};
  endfunction

  function automatic f64_t rand_special();
    f64_t v;
    case ($urandom_range(9))
      0: v = PosZero;
      1: v = InfBits;
      2: v = QnanBits;
      3: v = SigNan | {12'd0, 20'($urandom), $urandom};
      4: v = MinSub;
      5: v = MaxSub;
      6: v = MinNorm;
      7: v = MaxFin;
      8: v = {12'd0, 20'($urandom), $urandom};   // random subnormal
      default: v = One;
    endcase
    v[63] = 1'($urandom_range(1));
    return v;
  endfunction

  // Values of modest magnitude, so running sums stay finite.
  function automatic f64_t rand_modest();
    f64_t v;
    v = rand_raw();
    v[62:52] = 11'(1023 - 12 + $urandom_range(24));
    return v;
  endfunction

  function automatic f64_t rand_value(int unsigned mix);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < mix) return rand_modest();
    if (pick < mix + (100 - mix) / 2) return rand_raw();
    return rand_special();
  endfunction

  // Broadcast a and b over the lanes, flipping the sign of a on rows 1 and 3 and of b on columns 2 and 3.
  function automatic in_req_t lanes(f64_t a, f64_t b, bit clr, bit last);
    in_req_t r;
    for (int i = 0; i < Dim; i++) begin
      r.a_row[i] = a ^ {(i == 1 || i == 3), 63'd0};
      r.b_col[i] = b ^ {(i == 2 || i == 3), 63'd0};
    end
    r.clear_first = clr;
    r.last_term   = last;
    return r;
  endfunction

  // Send one request; returns at the edge where it was taken.
  task automatic send_request(in_req_t r);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    apply_request(r);
  endtask

  task automatic wait_rows_drained();
    in_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rows_due.size() == 0) begin
        $error("unexpected row result, tile_row %0d", out_ch.data.tile_row);
        errors++;
      end else begin
        out_req_t want;
        want = rows_due.pop_front();
        if (out_ch.data.tile_row !== want.tile_row) begin
          $error("tile_row: expected %0d, got %0d", want.tile_row, out_ch.data.tile_row);
          errors++;
        end
        for (int j = 0; j < Dim; j++) begin
          if (out_ch.data.sum_col[j] !== want.sum_col[j]) begin
            $error("sum_col%0d (row %0d): expected %h, got %h", j, want.tile_row,
                   want.sum_col[j], out_ch.data.sum_col[j]);
            errors++;
          end
        end
        if (out_ch.data.last_row !== want.last_row) begin
          $error("last_row: expected %0d, got %0d", want.last_row, out_ch.data.last_row);
          errors++;
        end
      end
      n_rows++;
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle);
  end

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLim) begin
      $display("timeout: no request moved for %0d cycles", StallLim);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // Extremes and the named special cases.
  task automatic test_directed();
    send_request(lanes(One, One, 1'b1, 1'b1));                // single-term tile
    send_request(lanes(MaxFin, MaxFin, 1'b0, 1'b1));          // overflow to inf
    send_request(lanes(InfBits, PosZero, 1'b1, 1'b1));        // inf times zero
    send_request(lanes(InfBits, One, 1'b1, 1'b0));            // inf, then inf - inf
    send_request(lanes(InfBits | NegZero, One, 1'b0, 1'b1));
    send_request(lanes(QnanBits, One, 1'b1, 1'b1));           // NaN operands
    send_request(lanes(One, SigNan, 1'b1, 1'b1));
    send_request(lanes(MinSub, One, 1'b1, 1'b0));             // subnormals kept
    send_request(lanes(MaxSub, MinNorm, 1'b0, 1'b0));
    send_request(lanes(64'h0170_0000_0000_0000, 64'h3B90_0000_0000_0000, 1'b0, 1'b1));
    send_request(lanes(One, 64'h4008_0000_0000_0000, 1'b1, 1'b0)); // exact cancel
    send_request(lanes(One | NegZero, 64'h4008_0000_0000_0000, 1'b0, 1'b1));
    send_request(lanes(NegZero, One, 1'b1, 1'b1));            // zero plus zero
    send_request(lanes(NegZero, NegZero, 1'b0, 1'b1));        // keeps running sums
    send_request(lanes(64'hFFFF_FFFF_FFFF_FFFF, PosZero, 1'b0, 1'b1));
    send_request(lanes(rand_modest(), rand_modest(), 1'b0, 1'b1)); // no clear
    send_request(lanes(MaxFin, 64'hBFF0_0000_0000_0001, 1'b1, 1'b1));
    wait_rows_drained();
  endtask

  // Well-formed tile sequences with random content, plus some noise.
  task automatic test_random(int unsigned n_items, int unsigned mix);
    int unsigned left, depth;
    in_req_t     r;
    left = n_items;
    while (left > 0) begin
      depth = $urandom_range(6, 1);
      for (int k = 0; k < depth && left > 0; k++) begin
        for (int i = 0; i < Dim; i++) begin
          r.a_row[i] = rand_value(mix);
          r.b_col[i] = rand_value(mix);
        end
        // mostly clean tiles; sometimes stray clears or lasts
        r.clear_first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        r.last_term   = (k == depth - 1) || ($urandom_range(24) == 0);
        send_request(r);
        left--;
      end
    end
  endtask

  // Sender holds off until every owed row has arrived.
  task automatic test_pause();
    send_request(lanes(rand_modest(), rand_modest(), 1'b1, 1'b1));
    wait_rows_drained();
    send_request(lanes(rand_modest(), rand_modest(), 1'b0, 1'b1));
    send_request(lanes(rand_modest(), rand_modest(), 1'b1, 1'b1));
    wait_rows_drained();
  endtask

  // No idling on either side: back-to-back requests and full-rate draining.
  task automatic test_full_rate();
    in_idle  = 0;
    out_idle = 0;
    test_random(60, 70);
    in_idle  = IdlePct;
    out_idle = IdlePct;
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    for (int i = 0; i < NumAcc; i++) acc_tile[i] = PosZero;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(120, 70);
    test_pause();
    test_full_rate();
    test_random(120, 40);
    test_random(50, 90);

    wait_rows_drained();
    repeat (DrainCyc) @(posedge clk);
    if (rows_due.size() != 0) begin
      $error("%0d expected rows never arrived", rows_due.size());
      errors++;
    end
    $display("covered %0d requests, %0d tiles, %0d rows: specials, subnormals,",
             n_sent, n_tiles, n_rows);
    $display("cancellation, overflow, chained tiles, back-pressure and full rate");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gta_pkg.sv
hdl/gta_if.sv
hdl/gta_fma.sv
hdl/gta_emit.sv
hdl/gemm_tile_4x4_accumulate.sv
bench/tb_gemm_tile_4x4_accumulate.sv
